>>> hdl/pmid_pkg.sv
// shared constants and types for the minimum-image distance block
`default_nettype none
package pmid_pkg;
  localparam int CoordW = 32;
  localparam int DiffW = 33;
  localparam int BoxW = 31;
  localparam int InvW = 33;
  localparam int MagW = 32;
  localparam int SqW = 64;
  localparam int SumW = 66;
  localparam int RootW = 33;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 33;
  localparam int InDataW = 192;
  localparam int OutDataW = 40;
  localparam int RootPerStage = 3;
  localparam int RootStages = 11;

  localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBoxX = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoxY = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBoxZ = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInvX = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvY = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInvZ = 3'd6;

  localparam logic [BoxW-1:0] BoxReset = 31'd65536;
  localparam logic [InvW-1:0] InvReset = 33'h1_0000_0000;

  typedef struct packed {
    logic [RootW-1:0] root;
    logic [SumW-1:0] rem;
    logic [SumW-1:0] rad;
  } root_t;
endpackage
`default_nettype wire

>>> hdl/pmid_wrap.sv
// one axis: difference, minimum-image wrap when mode is set, and saturated magnitude, four stages
`default_nettype none
module pmid_wrap (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic mode,
  input  wire logic [pmid_pkg::CoordW-1:0] a,
  input  wire logic [pmid_pkg::CoordW-1:0] b,
  input  wire logic [pmid_pkg::BoxW-1:0] len,
  input  wire logic [pmid_pkg::InvW-1:0] inv,
  output logic [pmid_pkg::MagW-1:0] mag
);
  logic neg2, neg3;
  logic signed [pmid_pkg::DiffW-1:0] d_c, d1, d2, d3;
  logic [pmid_pkg::DiffW-1:0] m1;
  logic [49:0] p2;
  logic [48:0] l2;
  logic [17:0] n3;
  logic [50:0] q16;
  logic [47:0] rem;
  logic [17:0] n_c;
  logic [48:0] ln_c;
  logic signed [51:0] w_c;
  logic [51:0] wm_c;

  always_comb begin
    d_c = 33'($signed(a)) - 33'($signed(b));
  end

  always_comb begin
    q16 = 51'(p2) + 51'(l2[48:16]);
    rem = {q16[31:0], l2[15:0]};
    n_c = q16[49:32];
    if (rem > 48'h8000_0000_0000 || (rem == 48'h8000_0000_0000 && n_c[0]))
      n_c = n_c + 18'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= d_c;
      m1 <= d_c[32] ? 33'(-d_c) : d_c;
      neg2 <= d1[32];
      d2 <= d1;
      p2 <= 50'(m1) * 50'(inv[32:16]);
      l2 <= 49'(m1) * 49'(inv[15:0]);
      neg3 <= neg2;
      d3 <= d2;
      n3 <= mode ? n_c : 18'd0;
      mag <= (wm_c > 52'hFFFF_FFFF) ? 32'hFFFF_FFFF : wm_c[31:0];
    end
  end

  always_comb begin
    ln_c = 49'(len) * 49'(n3);
    w_c = 52'($signed(d3)) - (neg3 ? -$signed({3'b0, ln_c}) : $signed({3'b0, ln_c}));
    wm_c = w_c[51] ? 52'(-w_c) : 52'(w_c);
  end
endmodule
`default_nettype wire

>>> hdl/pmid_root.sv
// pipelined restoring square root of the 66-bit sum, three bits per stage
`default_nettype none
module pmid_root (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [pmid_pkg::SumW-1:0] sum,
  output logic [pmid_pkg::RootW-1:0] root
);
  pmid_pkg::root_t st [pmid_pkg::RootStages+1];
  pmid_pkg::root_t nx [pmid_pkg::RootStages];

  assign st[0] = '{root: '0, rem: '0, rad: sum};

  for (genvar s = 0; s < pmid_pkg::RootStages; s++) begin : g_stage
    always_comb begin
      pmid_pkg::root_t t;
      logic [pmid_pkg::SumW+1:0] trial;
      logic [pmid_pkg::SumW+1:0] r2;
      t = st[s];
      for (int k = 0; k < pmid_pkg::RootPerStage; k++) begin
        r2 = {t.rem, t.rad[pmid_pkg::SumW-1 -: 2]};
        trial = {t.root, 2'b01};
        t.rad = {t.rad[pmid_pkg::SumW-3:0], 2'b00};
        if (r2 >= trial) begin
          t.rem = pmid_pkg::SumW'(r2 - trial);
          t.root = {t.root[pmid_pkg::RootW-2:0], 1'b1};
        end else begin
          t.rem = pmid_pkg::SumW'(r2);
          t.root = {t.root[pmid_pkg::RootW-2:0], 1'b0};
        end
      end
      nx[s] = t;
    end
    always_ff @(posedge clk) begin
      if (en) st[s+1] <= nx[s];
    end
  end

  assign root = st[pmid_pkg::RootStages].root;
endmodule
`default_nettype wire

>>> hdl/periodic_min_image_distance.sv
// top level: minimum-image distance pipeline with register file and stream ports
// channel | dir | fields (tdata low bit up)                 | tuser
// s_axis  | in  | a_x a_y a_z b_x b_y b_z (192 bits)        | last_pair in tlast
// m_axis  | out | separation, 7 zero bits (40 bits)         | last_pair_out in tlast
// cfg     | in  | cfg_we, cfg_idx (3), cfg_data (33)        | -
// one request per cycle while the output is not stalled; stages: 4 wrap, 1 square, 1 sum, 11 root, 1 out
// the whole pipeline advances together, so a stalled output holds every stage
// rst clears valid bits and sets config registers to reset values; payload registers are not reset
`default_nettype none
module periodic_min_image_distance (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [pmid_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [pmid_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [pmid_pkg::InDataW-1:0] s_axis_tdata, // a_x a_y a_z b_x b_y b_z
  input  wire logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [pmid_pkg::OutDataW-1:0] m_axis_tdata, // separation, zero fill
  output logic m_axis_tlast
);
  localparam int Depth = 4 + 2 + pmid_pkg::RootStages;

  logic mode;
  logic [pmid_pkg::BoxW-1:0] box_x, box_y, box_z;
  logic [pmid_pkg::InvW-1:0] inv_x, inv_y, inv_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      box_x <= pmid_pkg::BoxReset;
      box_y <= pmid_pkg::BoxReset;
      box_z <= pmid_pkg::BoxReset;
      inv_x <= pmid_pkg::InvReset;
      inv_y <= pmid_pkg::InvReset;
      inv_z <= pmid_pkg::InvReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        pmid_pkg::RegMode: mode <= cfg_data[0];
        pmid_pkg::RegBoxX: box_x <= cfg_data[pmid_pkg::BoxW-1:0];
        pmid_pkg::RegBoxY: box_y <= cfg_data[pmid_pkg::BoxW-1:0];
        pmid_pkg::RegBoxZ: box_z <= cfg_data[pmid_pkg::BoxW-1:0];
        pmid_pkg::RegInvX: inv_x <= cfg_data;
        pmid_pkg::RegInvY: inv_y <= cfg_data;
        pmid_pkg::RegInvZ: inv_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Depth-1:0] vld;
  logic [Depth-1:0] lst;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [pmid_pkg::MagW-1:0] mx, my, mz;
  pmid_wrap u_wx (.clk, .en, .mode, .a(s_axis_tdata[31:0]), .b(s_axis_tdata[127:96]),
    .len(box_x), .inv(inv_x), .mag(mx));
  pmid_wrap u_wy (.clk, .en, .mode, .a(s_axis_tdata[63:32]), .b(s_axis_tdata[159:128]),
    .len(box_y), .inv(inv_y), .mag(my));
  pmid_wrap u_wz (.clk, .en, .mode, .a(s_axis_tdata[95:64]), .b(s_axis_tdata[191:160]),
    .len(box_z), .inv(inv_z), .mag(mz));

  logic [pmid_pkg::SqW-1:0] sx, sy, sz;
  logic [pmid_pkg::SumW-1:0] sum;
  always_ff @(posedge clk) begin
    if (en) begin
      sx <= 64'(mx) * 64'(mx);
      sy <= 64'(my) * 64'(my);
      sz <= 64'(mz) * 64'(mz);
      sum <= 66'(sx) + 66'(sy) + 66'(sz);
    end
  end

  logic [pmid_pkg::RootW-1:0] root;
  pmid_root u_root (.clk, .en, .sum, .root);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], s_axis_tvalid};
      m_axis_tvalid <= vld[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst <= {lst[Depth-2:0], s_axis_tlast};
      m_axis_tlast <= lst[Depth-1];
      m_axis_tdata <= {7'd0, root};
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tdata[pmid_pkg::OutDataW-1:pmid_pkg::RootW] == '0)
    else $error("fill bits set");
`endif
endmodule
`default_nettype wire
